// ===== sv/mkd_pkg.sv =====
// Package for the straight-key decoder: fixed field widths, register map
// and the symbol-pattern to ASCII letter table. No dependencies.
`default_nettype none

package mkd_pkg;

  localparam int unsigned ElapsedW = 16;
  localparam int unsigned LockW    = 10;
  localparam int unsigned LetterW  = 7;
  localparam int unsigned PaddrW   = 4;
  localparam int unsigned PdataW   = 32;

  typedef logic [LetterW-1:0] letter_t;

  typedef enum logic [1:0] {
    REG_DOT_MAX    = 2'd0,
    REG_LETTER_GAP = 2'd1,
    REG_LOCKOUT    = 2'd2
  } reg_idx_t;

  localparam logic [ElapsedW-1:0] DotMaxRst    = 16'd400;
  localparam logic [ElapsedW-1:0] LetterGapRst = 16'd800;
  localparam logic [LockW-1:0]    LockoutRst   = 10'd200;
  localparam letter_t             LetterUnknown = 7'd63;

  // Index is {leading 1 marker, symbols}, newest symbol in bit 0, dash = 1.
  // Entries are 8-bit ASCII; the top bit is always zero.
  localparam logic [7:0] LetterTable [32] = '{
    8'd63, 8'd63,
    "E", "T",
    "I", "A", "N", "M",
    "S", "U", "R", "W", "D", "K", "G", "O",
    "H", "V", "F", 8'd63, "L", 8'd63, "P", "J",
    "B", "X", "C", "Y", "Z", "Q", 8'd63, 8'd63
  };

endpackage

`default_nettype wire

// ===== sv/morse_key_decoder.sv =====
// Straight-key Morse decoder top level: one sampled key level per request,
// zero or one ASCII letter out. Uses mkd_pkg for widths, registers and table.
//
//  channel  | handshake                     | payload
//  ---------+-------------------------------+-------------------------------
//  input    | in_valid / in_ready           | in_key_down (1 bit)
//  result   | out_valid / out_ready         | out_letter (7 bits)
//  config   | psel penable pwrite, pready=1 | paddr[3:0], pwdata / prdata
//
// One request per clock while in_ready is high. At the accepting edge the
// tick state updates and a new letter enters the result register, or the skid
// register if a letter there is not taken. The two-entry output buffer lets
// input flow while a letter waits; in_ready falls only when both hold letters.
// Reset is synchronous, active low: registers 400 / 800 / 200, symbols empty.
`default_nettype none

module morse_key_decoder
  import mkd_pkg::*;
#(
  parameter int unsigned MAX_SYMBOLS = 4
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                in_key_down,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output letter_t                  out_letter,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [PaddrW-1:0]   paddr,
  input  wire logic [PdataW-1:0]   pwdata,
  output logic      [PdataW-1:0]   prdata,
  output logic                     pready
);

  localparam int unsigned CntW = $clog2(MAX_SYMBOLS + 2);
  localparam logic [CntW-1:0] CntMax  = CntW'(MAX_SYMBOLS);
  localparam logic [CntW-1:0] CntOver = CntW'(MAX_SYMBOLS + 1);
  localparam logic [CntW-1:0] CntTableMax = CntW'(4);

  // configuration
  logic [ElapsedW-1:0] dot_max_r, letter_gap_r;
  logic [LockW-1:0]    lockout_r;
  logic                cfg_wr;
  reg_idx_t            cfg_idx;

  // tick state
  logic                   pressed_r, pressed_nxt;
  logic [ElapsedW-1:0]    elapsed_r, elapsed_nxt, elapsed_inc;
  logic [LockW-1:0]       lock_left_r, lock_left_nxt;
  logic [MAX_SYMBOLS-1:0] sym_bits_r, sym_bits_nxt, sym_bits_app;
  logic [CntW-1:0]        sym_cnt_r, sym_cnt_nxt, sym_cnt_app;

  // output buffer
  logic    out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;
  letter_t out_letter_r, out_letter_nxt, skid_letter_r, skid_letter_nxt;

  logic    accept, emit, pop, edge_seen, dash;
  letter_t letter_new;
  logic [4:0] tbl_idx;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_max_r    <= DotMaxRst;
      letter_gap_r <= LetterGapRst;
      lockout_r    <= LockoutRst;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_DOT_MAX:    dot_max_r    <= pwdata[ElapsedW-1:0];
        REG_LETTER_GAP: letter_gap_r <= pwdata[ElapsedW-1:0];
        REG_LOCKOUT:    lockout_r    <= pwdata[LockW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_DOT_MAX:    prdata = {{(PdataW-ElapsedW){1'b0}}, dot_max_r};
      REG_LETTER_GAP: prdata = {{(PdataW-ElapsedW){1'b0}}, letter_gap_r};
      REG_LOCKOUT:    prdata = {{(PdataW-LockW){1'b0}}, lockout_r};
      default:        prdata = '0;
    endcase
  end

  assign in_ready = !skid_valid_r;
  assign accept   = in_valid && in_ready;

  // one tick of the key state
  always_comb begin
    elapsed_inc = (elapsed_r == '1) ? elapsed_r : elapsed_r + ElapsedW'(1);
    edge_seen   = (in_key_down != pressed_r);
    dash        = (elapsed_inc > dot_max_r);

    sym_bits_app = sym_bits_r;
    sym_cnt_app  = sym_cnt_r;
    if (edge_seen && !in_key_down) begin
      if (sym_cnt_r >= CntMax) begin
        sym_cnt_app = CntOver;
      end else begin
        sym_bits_app = {sym_bits_r[MAX_SYMBOLS-2:0], dash};
        sym_cnt_app  = sym_cnt_r + CntW'(1);
      end
    end

    pressed_nxt   = pressed_r;
    elapsed_nxt   = elapsed_inc;
    lock_left_nxt = lock_left_r;
    sym_bits_nxt  = sym_bits_r;
    sym_cnt_nxt   = sym_cnt_r;
    emit          = 1'b0;

    if (lock_left_r != '0) begin
      lock_left_nxt = lock_left_r - LockW'(1);
    end else begin
      pressed_nxt  = in_key_down;
      sym_bits_nxt = sym_bits_app;
      sym_cnt_nxt  = sym_cnt_app;
      if (edge_seen) begin
        elapsed_nxt   = '0;
        lock_left_nxt = lockout_r;
      end
      if (!in_key_down && sym_cnt_app != '0 && elapsed_nxt > letter_gap_r) begin
        emit         = accept;
        sym_bits_nxt = '0;
        sym_cnt_nxt  = '0;
      end
    end
  end

  // letter lookup on the buffer as it stands after this tick's append
  always_comb begin
    tbl_idx = {1'b0, sym_bits_app[3:0]} | (5'd1 << sym_cnt_app);
    if (sym_cnt_app != '0 && sym_cnt_app <= CntTableMax) begin
      letter_new = LetterTable[tbl_idx][LetterW-1:0];
    end else begin
      letter_new = LetterUnknown;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_r   <= 1'b0;
      elapsed_r   <= '0;
      lock_left_r <= '0;
      sym_bits_r  <= '0;
      sym_cnt_r   <= '0;
    end else if (accept) begin
      pressed_r   <= pressed_nxt;
      elapsed_r   <= elapsed_nxt;
      lock_left_r <= lock_left_nxt;
      sym_bits_r  <= sym_bits_nxt;
      sym_cnt_r   <= sym_cnt_nxt;
    end
  end

  // result register with skid entry behind it
  assign pop = out_valid_r && out_ready;

  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_letter_nxt  = out_letter_r;
    skid_valid_nxt  = skid_valid_r;
    skid_letter_nxt = skid_letter_r;
    if (pop) begin
      if (skid_valid_r) begin
        out_letter_nxt = skid_letter_r;
        skid_valid_nxt = 1'b0;
      end else if (emit) begin
        out_letter_nxt = letter_new;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (emit) begin
      if (!out_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_letter_nxt = letter_new;
      end else begin
        skid_valid_nxt  = 1'b1;
        skid_letter_nxt = letter_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_letter_r  <= out_letter_nxt;
    skid_letter_r <= skid_letter_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_letter = out_letter_r;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry holds a letter while result register is empty");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    sym_cnt_r <= CntOver)
    else $error("symbol count beyond overflow mark");

  a_empty_buffer: assert property (@(posedge clk) disable iff (!rst_n)
    (sym_cnt_r == '0) |-> (sym_bits_r == '0))
    else $error("symbol bits left over in an empty buffer");

  a_lockout_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && lock_left_r != '0) |=> (sym_cnt_r == $past(sym_cnt_r)))
    else $error("symbol buffer changed during lockout");
`endif

endmodule

`default_nettype wire

// ===== verif/mkd_letter_checker.sv =====
// Letter checker for the straight-key decoder: watches the key, letter and
// register ports, predicts the letter stream and compares it in order.
// Depends on mkd_pkg for widths, register indexes and the unknown letter code.
module mkd_letter_checker
  import mkd_pkg::*;
#(
  parameter int unsigned MaxSym = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              in_key_down,
  input  logic              out_valid,
  input  logic              out_ready,
  input  letter_t           out_letter,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  input  logic [PdataW-1:0] prdata,
  input  logic              drain_done,
  output int unsigned       mismatches,
  output int unsigned       pending,
  output int unsigned       letters_checked,
  output int unsigned       ticks_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  // indexed by {marker 1, symbols}, dash = 1, newest symbol in bit 0
  string letter_order = "??ETIANMSURWDKGOHVF?L?PJBXCYZQ??";

  logic [ElapsedW-1:0] dot_max;
  logic [ElapsedW-1:0] letter_gap;
  logic [LockW-1:0]    lockout;

  logic                pressed;
  logic [ElapsedW-1:0] elapsed;
  logic [LockW-1:0]    lock_left;
  logic [MaxSym-1:0]   sym_bits;
  logic [2:0]          sym_count;

  letter_t letters_due[$];
  bit      drain_checked;

  task automatic append_symbol(input logic dash);
    if (sym_count >= MaxSym) begin
      sym_count = 3'(MaxSym + 1);
    end else begin
      sym_bits  = {sym_bits[MaxSym-2:0], dash};
      sym_count = sym_count + 3'd1;
    end
  endtask

  // One millisecond tick of the key decoder.
  task automatic key_tick(input logic key);
    int unsigned idx;
    if (elapsed != '1) elapsed = elapsed + 1'b1;
    if (lock_left != '0) begin
      lock_left = lock_left - 1'b1;
      return;
    end
    if (key && !pressed) begin
      pressed   = 1'b1;
      elapsed   = '0;
      lock_left = lockout;
    end else if (!key && pressed) begin
      pressed = 1'b0;
      append_symbol(elapsed > dot_max);
      elapsed   = '0;
      lock_left = lockout;
    end
    if (!pressed && sym_count != 0 && elapsed > letter_gap) begin
      if (sym_count <= 4) begin
        idx = (32'd1 << sym_count) | (32'(sym_bits) & 32'd15);
        letters_due.push_back(letter_t'(letter_order[idx]));
      end else begin
        letters_due.push_back(LetterUnknown);
      end
      sym_bits  = '0;
      sym_count = '0;
    end
  endtask

  always @(posedge clk) begin
    letter_t  want;
    reg_idx_t idx;
    logic [PdataW-1:0] reg_val;
    if (!rst_n) begin
      dot_max    = DotMaxRst;
      letter_gap = LetterGapRst;
      lockout    = LockoutRst;
      pressed    = 1'b0;
      elapsed    = '0;
      lock_left  = '0;
      sym_bits   = '0;
      sym_count  = '0;
      letters_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        letters_checked++;
        if (letters_due.size() == 0) begin
          $error("out_letter: no letter expected, actual %0d", out_letter);
          mismatches++;
        end else begin
          want = letters_due.pop_front();
          if (out_letter !== want) begin
            $error("out_letter: expected %0d ('%c'), actual %0d", want, want, out_letter);
            mismatches++;
          end
        end
      end

      if (psel && penable && pready) begin
        idx = reg_idx_t'(paddr[3:2]);
        if (pwrite) begin
          case (idx)
            REG_DOT_MAX:    dot_max    = pwdata[ElapsedW-1:0];
            REG_LETTER_GAP: letter_gap = pwdata[ElapsedW-1:0];
            REG_LOCKOUT:    lockout    = pwdata[LockW-1:0];
            default: ;
          endcase
        end else begin
          case (idx)
            REG_DOT_MAX:    reg_val = PdataW'(dot_max);
            REG_LETTER_GAP: reg_val = PdataW'(letter_gap);
            default:        reg_val = PdataW'(lockout);
          endcase
          if (prdata !== reg_val) begin
            $error("prdata (%s): expected %0d, actual %0d", idx.name(), reg_val, prdata);
            mismatches++;
          end
        end
      end

      if (in_valid && in_ready) begin
        ticks_seen++;
        key_tick(in_key_down);
      end

      if (drain_done && !drain_checked) begin
        drain_checked = 1'b1;
        if (letters_due.size() != 0) begin
          $error("out_letter: %0d expected letters never arrived, next %0d",
                 letters_due.size(), letters_due[0]);
          mismatches += letters_due.size();
        end
      end
    end
    pending = letters_due.size();
  end

endmodule

// ===== verif/tb_top.sv =====
// Top of the straight-key decoder testbench: clock, reset, key-tick and
// register stimulus, result-side pacing, watchdog and verdict.
// Depends on mkd_pkg, morse_key_decoder and mkd_letter_checker.
module tb_top;
  import mkd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxSym      = 4;
  localparam int unsigned RandomTicks = 700;
  localparam int unsigned PhaseTicks  = 150;
  localparam int unsigned StallLimit  = 2000;

  logic              clk;
  logic              rst_n       = 1'b0;
  logic              in_valid    = 1'b0;
  logic              in_key_down = 1'b0;
  logic              out_ready   = 1'b0;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [PaddrW-1:0] paddr       = '0;
  logic [PdataW-1:0] pwdata      = '0;
  logic              drain_done  = 1'b0;

  logic              in_ready;
  logic              out_valid;
  letter_t           out_letter;
  logic [PdataW-1:0] prdata;
  logic              pready;

  int unsigned mismatches, pending, letters_checked, ticks_seen;

  // current register values, used only to shape key timing
  int unsigned cur_dot  = DotMaxRst;
  int unsigned cur_gap  = LetterGapRst;
  int unsigned cur_lock = LockoutRst;
  int unsigned settings = 1;
  bit          no_gaps  = 1'b0;
  int unsigned idle_cycles = 0;

  morse_key_decoder #(.MAX_SYMBOLS(MaxSym)) u_dut (.*);

  mkd_letter_checker #(.MaxSym(MaxSym)) u_checker (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // watchdog: any request on any port resets the count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // letter-side pacing: ready bursts, short stalls, a few long ones
  initial begin : out_pacing
    bit          stall;
    int unsigned span;
    forever begin
      stall = ($urandom_range(0, 3) == 0);
      if (stall) begin
        span = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
      end else begin
        span = $urandom_range(1, 40);
      end
      out_ready <= !stall;
      repeat (span) @(posedge clk);
    end
  end

  function automatic int unsigned sender_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // all tasks below are entered just after a rising edge
  task automatic send_tick(input logic key);
    int unsigned idle;
    bit          taken;
    idle = sender_gap();
    if (idle != 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_key_down <= key;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic hold_key(input logic key, input int unsigned n);
    repeat (n) send_tick(key);
  endtask

  // wait until every letter is out and the block has had time to settle
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_access(input reg_idx_t idx, input logic wr, input int unsigned data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= PdataW'(data);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic read_back();
    reg_access(REG_DOT_MAX, 1'b0, 0);
    reg_access(REG_LETTER_GAP, 1'b0, 0);
    reg_access(REG_LOCKOUT, 1'b0, 0);
  endtask

  task automatic set_config(input int unsigned dot_ms, gap_ms, lock_ms);
    settle();
    reg_access(REG_DOT_MAX, 1'b1, dot_ms);
    reg_access(REG_LETTER_GAP, 1'b1, gap_ms);
    reg_access(REG_LOCKOUT, 1'b1, lock_ms);
    read_back();
    cur_dot  = dot_ms;
    cur_gap  = gap_ms;
    cur_lock = lock_ms;
    settings++;
  endtask

  // Well-formed letter: first symbol sent first, held in the top bit of pattern.
  task automatic send_letter(input int unsigned nsym, input int unsigned pattern);
    int unsigned dur;
    bit          dash;
    for (int unsigned i = 0; i < nsym; i++) begin
      dash = 1'((pattern >> (nsym - 1 - i)) & 1);
      dur  = dash ? $urandom_range(cur_dot + 1, cur_dot + 4) : $urandom_range(1, cur_dot);
      if (dur <= cur_lock) dur = cur_lock + 1;
      hold_key(1'b1, dur);
      if (i + 1 < nsym) begin
        hold_key(1'b0, $urandom_range(cur_lock + 1, (cur_gap > cur_lock) ? cur_gap : cur_lock + 1));
      end
    end
    hold_key(1'b0, cur_gap + cur_lock + $urandom_range(2, 5));
  endtask

  initial begin : stimulus
    int unsigned rand_start, phase_start, r, phase;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: read back, then one dot at the default timing
    read_back();
    hold_key(1'b1, 300);
    hold_key(1'b0, 810);

    // zero letter gap, no lockout: single symbols, unknown and too-long patterns
    set_config(2, 0, 0);
    send_letter(1, 4'b0000);
    send_letter(1, 4'b0001);
    send_letter(4, 4'b0101);
    send_letter(5, 5'b10110);
    hold_key(1'b1, 6);
    hold_key(1'b0, 3);

    // random part: mostly well-formed letters at short, varied timing
    rand_start = ticks_seen;
    phase = 0;
    while (ticks_seen - rand_start < RandomTicks) begin
      case (phase)
        0:       set_config(1, 0, 0);
        1:       set_config(6, 12, 3);
        default: set_config($urandom_range(1, 6), $urandom_range(0, 12), $urandom_range(0, 3));
      endcase
      phase++;
      phase_start = ticks_seen;
      while (ticks_seen - phase_start < PhaseTicks && ticks_seen - rand_start < RandomTicks) begin
        r = $urandom_range(0, 99);
        no_gaps = ($urandom_range(0, 4) == 0);
        if (r < 80) begin
          send_letter(($urandom_range(0, 9) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 4),
                      $urandom());
          if ($urandom_range(0, 29) == 0) settle();
        end else if (r < 92) begin
          repeat ($urandom_range(1, 12)) hold_key(1'($urandom_range(0, 1)), $urandom_range(1, 6));
        end else begin
          // press cut short inside the lockout or just at its end, then a short release
          hold_key(1'b1, $urandom_range(1, cur_lock + 1));
          hold_key(1'b0, $urandom_range(1, 3));
        end
      end
    end
    no_gaps = 1'b0;

    // extremes: longest lockout swallows the key changes that follow the press
    set_config(16'hFFFF, 16'hFFFF, 10'h3FF);
    hold_key(1'b1, 4);
    hold_key(1'b0, 4);
    hold_key(1'b1, 4);
    hold_key(1'b0, 4);

    settle();
    repeat (8) @(posedge clk);
    drain_done <= 1'b1;
    @(posedge clk);
    @(negedge clk);
    $display("Covered %0d key ticks under %0d register settings (defaults, zero gap,",
             ticks_seen, settings);
    $display("lockout up to 1023, gap 65535); %0d decoded letters compared in order.",
             letters_checked);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
